// ===== rtl/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_pkg
// Shared types and constants of the deadline scheduler.
// ----------------------------------------------------------------------------
package edf_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int SLOT_W = $clog2(QUEUE_DEPTH);

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_TICK   = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		EV_ACCEPTED = 3'd0,
		EV_REJECTED = 3'd1,
		EV_DROPPED  = 3'd2,
		EV_RAN      = 3'd3,
		EV_DONE     = 3'd4,
		EV_IDLE     = 3'd5,
		EV_HALTED   = 3'd6
	} event_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] task_id;
		logic [15:0] burst_length;
		logic [31:0] deadline_tick;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [15:0] task_id_out;
		logic [31:0] now_tick;
		logic [31:0] completed_count;
		logic [31:0] failed_count;
		logic [47:0] turnaround_sum;
		logic        last;
	} out_item_t;

	// One entry of the task store.
	typedef struct packed {
		logic [15:0] task_id;
		logic [31:0] deadline;
		logic [15:0] burst;
		logic [15:0] served;
		logic [31:0] arrival;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_EVAL,
		ST_EMIT
	} state_t;

endpackage

// ===== rtl/edf_store.sv =====
// ----------------------------------------------------------------------------
// edf_store
// Task entry memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module edf_store (
	input  logic          clk,
	input  logic          we,
	input  edf_pkg::slot_t waddr,
	input  edf_pkg::entry_t wdata,
	input  edf_pkg::slot_t raddr,
	output edf_pkg::entry_t rdata
);
	import edf_pkg::*;

	entry_t mem [QUEUE_DEPTH];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/edf_deadline_scheduler.sv =====
// ----------------------------------------------------------------------------
// edf_deadline_scheduler
// Earliest-deadline-first scheduler with a sixteen-entry task store.
// ----------------------------------------------------------------------------
// One item is handled at a time. An arrive beat is accepted in IDLE, then
// its result is raised in EMIT and held valid until the receiver takes it.
// A tick beat scans the task memory one entry a cycle through the single
// read port, then reads the chosen entry back, evaluates it and emits a
// result; with an empty store the evaluation is skipped and an idle result
// goes out. In soft mode each dropped task repeats the pass; in hard mode a
// drop is followed by a halt beat. Any result beat waits while the receiver
// stalls, so a tick holds the block until its last result beat is taken.
// Valid bits live in flip-flops; entry contents live in memory.
module edf_deadline_scheduler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  edf_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output edf_pkg::out_item_t  out_data
);
	import edf_pkg::*;

	localparam logic [SLOT_W:0] LAST_IDX = (SLOT_W+1)'(QUEUE_DEPTH - 1);

	state_t state_q, state_d;
	logic hard_q, halted_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [31:0] tick_q, done_q, fail_q;
	logic [47:0] ta_q;
	logic [SLOT_W:0] scan_q;       // address issued this cycle
	logic rd_pend_s1;              // read data of scan_q-1 arrives
	slot_t rd_slot_s1;
	logic best_ok_q;
	slot_t best_q;
	logic [31:0] best_dl_q;
	logic [15:0] best_id_q;
	out_item_t res_q;

	logic we;
	slot_t waddr, raddr;
	entry_t wdata, rdata;

	edf_store u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// First free slot for arrivals.
	logic free_ok;
	slot_t free_slot;
	always_comb begin
		free_ok = 1'b0;
		free_slot = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_ok = 1'b1;
				free_slot = slot_t'(i);
			end
		end
	end

	// Evaluation of the chosen entry.
	logic [15:0] served_inc;
	logic [32:0] need;
	logic late, finish;
	logic [31:0] ta_inc;
	logic [48:0] ta_sum;
	always_comb begin
		served_inc = rdata.served + 16'd1;
		need = {1'b0, tick_q} + 33'(rdata.burst - rdata.served);
		late = need > {1'b0, rdata.deadline};
		finish = served_inc >= rdata.burst;
		ta_inc = tick_q - rdata.arrival;
		ta_sum = {1'b0, ta_q} + 49'(ta_inc);
	end

	assign raddr = (state_q == ST_READ) ? best_q : scan_q[SLOT_W-1:0];
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					if (halted_q || in_data.opcode == OP_ARRIVE) state_d = ST_EMIT;
					else state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_pend_s1 && rd_slot_s1 == LAST_IDX[SLOT_W-1:0]) state_d = ST_READ;
			end
			ST_READ: state_d = best_ok_q ? ST_EVAL : ST_EMIT;
			ST_EVAL: state_d = ST_EMIT;
			ST_EMIT: begin
				// Leave only once the result beat has been taken.
				if (out_valid && out_ready) begin
					if (res_q.last) state_d = ST_IDLE;
					else if (hard_q) state_d = ST_EMIT;
					else state_d = ST_SCAN;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Memory write: arrival when accepted in IDLE, service update in EVAL.
	always_comb begin
		we = 1'b0;
		waddr = best_q;
		wdata = rdata;
		if (state_q == ST_EVAL && !late) begin
			we = 1'b1;
			wdata.served = served_inc;
		end else if (state_q == ST_IDLE && in_valid && in_ready && !halted_q &&
			in_data.opcode == OP_ARRIVE && free_ok) begin
			we = 1'b1;
			waddr = free_slot;
			wdata.task_id = in_data.task_id;
			wdata.deadline = in_data.deadline_tick;
			wdata.burst = (in_data.burst_length == 16'd0) ? 16'd1 : in_data.burst_length;
			wdata.served = 16'd0;
			wdata.arrival = tick_q;
		end
	end

	// Control and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hard_q <= 1'b0;
			halted_q <= 1'b0;
			valid_q <= '0;
			tick_q <= '0;
			done_q <= '0;
			fail_q <= '0;
			ta_q <= '0;
			scan_q <= '0;
			rd_pend_s1 <= 1'b0;
			rd_slot_s1 <= '0;
			best_ok_q <= 1'b0;
			best_q <= '0;
			best_dl_q <= '0;
			best_id_q <= '0;
			out_valid <= 1'b0;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) hard_q <= cfg_wdata;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					rd_pend_s1 <= 1'b0;
					best_ok_q <= 1'b0;
					if (in_valid && in_ready) begin
						res_q.last <= 1'b1;
						res_q.now_tick <= tick_q;
						res_q.completed_count <= done_q;
						res_q.failed_count <= fail_q;
						res_q.turnaround_sum <= ta_q;
						if (halted_q) begin
							res_q.event_kind <= EV_HALTED;
							res_q.task_id_out <= '0;
						end else if (in_data.opcode == OP_ARRIVE) begin
							res_q.task_id_out <= in_data.task_id;
							res_q.event_kind <= free_ok ? EV_ACCEPTED : EV_REJECTED;
							if (free_ok) valid_q[free_slot] <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (scan_q <= LAST_IDX) scan_q <= scan_q + 1'b1;
					rd_pend_s1 <= (scan_q <= LAST_IDX);
					rd_slot_s1 <= scan_q[SLOT_W-1:0];
					if (rd_pend_s1 && valid_q[rd_slot_s1]) begin
						if (!best_ok_q || rdata.deadline < best_dl_q ||
							(rdata.deadline == best_dl_q && rdata.task_id < best_id_q)) begin
							best_ok_q <= 1'b1;
							best_q <= rd_slot_s1;
							best_dl_q <= rdata.deadline;
							best_id_q <= rdata.task_id;
						end
					end
				end
				ST_READ: begin
					if (!best_ok_q) begin
						tick_q <= tick_q + 32'd1;
						res_q <= '{event_kind: EV_IDLE, task_id_out: '0,
							now_tick: tick_q + 32'd1, completed_count: done_q,
							failed_count: fail_q, turnaround_sum: ta_q, last: 1'b1};
					end
				end
				ST_EVAL: begin
					res_q.task_id_out <= rdata.task_id;
					res_q.completed_count <= done_q;
					res_q.turnaround_sum <= ta_q;
					if (late) begin
						valid_q[best_q] <= 1'b0;
						fail_q <= (fail_q == '1) ? fail_q : fail_q + 32'd1;
						res_q.failed_count <= (fail_q == '1) ? fail_q : fail_q + 32'd1;
						res_q.now_tick <= tick_q;
						res_q.event_kind <= EV_DROPPED;
						res_q.last <= 1'b0;
					end else begin
						tick_q <= tick_q + 32'd1;
						res_q.now_tick <= tick_q + 32'd1;
						res_q.failed_count <= fail_q;
						res_q.last <= 1'b1;
						if (finish) begin
							valid_q[best_q] <= 1'b0;
							done_q <= (done_q == '1) ? done_q : done_q + 32'd1;
							res_q.completed_count <= (done_q == '1) ? done_q : done_q + 32'd1;
							ta_q <= ta_sum[48] ? '1 : ta_sum[47:0];
							res_q.turnaround_sum <= ta_sum[48] ? '1 : ta_sum[47:0];
							res_q.event_kind <= EV_DONE;
						end else begin
							res_q.event_kind <= EV_RAN;
						end
					end
				end
				ST_EMIT: begin
					scan_q <= '0;
					rd_pend_s1 <= 1'b0;
					best_ok_q <= 1'b0;
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (out_ready) begin
						// A drop beat went out; halt or rescan.
						if (!res_q.last) begin
							if (hard_q) begin
								halted_q <= 1'b1;
								res_q.event_kind <= EV_HALTED;
								res_q.task_id_out <= '0;
								res_q.last <= 1'b1;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// The result beat comes straight from the result register.
	always_comb begin
		out_data = res_q;
	end

`ifndef SYNTH
	// A result beat only leaves while the emit state holds it.
	a_out_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_EMIT)
		else $error("result valid outside emit");
	// Once halted, the block stays halted.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt flag cleared");
	// No new item is taken while a result is pending.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accepted while result pending");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the deadline scheduler: random and directed task
// beats, a behavioral scheduler that predicts every result beat, and a
// monitor that compares them field by field.
// ----------------------------------------------------------------------------
module tb;
	import edf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = QUEUE_DEPTH;
	localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	edf_deadline_scheduler dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #10 clk = ~clk;

	// Predicted scheduler state.
	logic        hard_q;
	logic        slot_used [DEPTH];
	entry_t      slot_q [DEPTH];
	logic [31:0] tick_q, done_q, fail_q;
	logic [47:0] tat_q;
	logic        halt_q;

	in_item_t  pending_beats [$];
	out_item_t expected_beats [$];
	int errors = 0;
	int sent = 0, got = 0, n_done = 0, n_drop = 0;
	int send_idle = 0, recv_idle = 0;

	task automatic push_event(input event_t kind, input logic [15:0] id);
		out_item_t r;
		r.event_kind = kind;
		r.task_id_out = id;
		r.now_tick = tick_q;
		r.completed_count = done_q;
		r.failed_count = fail_q;
		r.turnaround_sum = tat_q;
		r.last = 1'b0;
		expected_beats.push_back(r);
	endtask

	// Schedules one accepted input beat and queues the results it causes.
	task automatic schedule_beat(input in_item_t it);
		int best, free_slot;
		logic [32:0] need;
		logic [31:0] prev_tick;
		logic [63:0] tsum;
		out_item_t r;
		if (halt_q) begin
			push_event(EV_HALTED, 16'd0);
		end else if (it.opcode == OP_ARRIVE) begin
			free_slot = -1;
			for (int i = 0; i < DEPTH; i++)
				if (!slot_used[i] && free_slot < 0) free_slot = i;
			if (free_slot < 0) begin
				push_event(EV_REJECTED, it.task_id);
			end else begin
				slot_used[free_slot] = 1'b1;
				slot_q[free_slot].task_id = it.task_id;
				slot_q[free_slot].burst = (it.burst_length == 0) ? 16'd1 : it.burst_length;
				slot_q[free_slot].deadline = it.deadline_tick;
				slot_q[free_slot].served = '0;
				slot_q[free_slot].arrival = tick_q;
				push_event(EV_ACCEPTED, it.task_id);
			end
		end else begin
			forever begin
				best = -1;
				for (int i = 0; i < DEPTH; i++) begin
					if (!slot_used[i]) continue;
					if (best < 0 || slot_q[i].deadline < slot_q[best].deadline ||
					    (slot_q[i].deadline == slot_q[best].deadline &&
					     slot_q[i].task_id < slot_q[best].task_id))
						best = i;
				end
				if (best < 0) begin
					tick_q = tick_q + 1;
					push_event(EV_IDLE, 16'd0);
					break;
				end
				need = {1'b0, tick_q} + (slot_q[best].burst - slot_q[best].served);
				if (need > {1'b0, slot_q[best].deadline}) begin
					slot_used[best] = 1'b0;
					if (fail_q != MAX32) fail_q = fail_q + 1;
					push_event(EV_DROPPED, slot_q[best].task_id);
					if (hard_q) begin
						halt_q = 1'b1;
						push_event(EV_HALTED, 16'd0);
						break;
					end
					continue;
				end
				prev_tick = tick_q;
				slot_q[best].served = slot_q[best].served + 16'd1;
				tick_q = tick_q + 1;
				if (slot_q[best].served >= slot_q[best].burst) begin
					slot_used[best] = 1'b0;
					if (done_q != MAX32) done_q = done_q + 1;
					tsum = {16'd0, tat_q} + {32'd0, prev_tick - slot_q[best].arrival};
					tat_q = (tsum > {16'd0, MAX48}) ? MAX48 : tsum[47:0];
					push_event(EV_DONE, slot_q[best].task_id);
				end else begin
					push_event(EV_RAN, slot_q[best].task_id);
				end
				break;
			end
		end
		r = expected_beats.pop_back();
		r.last = 1'b1;
		expected_beats.push_back(r);
	endtask

	// Driver: presents queued beats, idling at random when allowed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				schedule_beat(in_data);
				sent++;
			end
			if (!(in_valid && !in_ready)) begin
				if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_data <= pending_beats.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Monitor: compares each result beat with the oldest prediction.
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			got++;
			if (expected_beats.size() == 0) begin
				$error("unexpected result beat kind %0d", out_data.event_kind);
				errors++;
			end else begin
				e = expected_beats.pop_front();
				if (out_data.event_kind == EV_DONE) n_done++;
				if (out_data.event_kind == EV_DROPPED) n_drop++;
				if (out_data.event_kind !== e.event_kind) begin
					$error("event_kind exp %0d got %0d", e.event_kind, out_data.event_kind);
					errors++;
				end
				if (out_data.task_id_out !== e.task_id_out) begin
					$error("task_id_out exp %0d got %0d", e.task_id_out, out_data.task_id_out);
					errors++;
				end
				if (out_data.now_tick !== e.now_tick) begin
					$error("now_tick exp %0d got %0d", e.now_tick, out_data.now_tick);
					errors++;
				end
				if (out_data.completed_count !== e.completed_count) begin
					$error("completed_count exp %0d got %0d",
						e.completed_count, out_data.completed_count);
					errors++;
				end
				if (out_data.failed_count !== e.failed_count) begin
					$error("failed_count exp %0d got %0d", e.failed_count, out_data.failed_count);
					errors++;
				end
				if (out_data.turnaround_sum !== e.turnaround_sum) begin
					$error("turnaround_sum exp %0d got %0d",
						e.turnaround_sum, out_data.turnaround_sum);
					errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, out_data.last);
					errors++;
				end
			end
		end
	end

	function automatic in_item_t make_beat(input logic op, input logic [15:0] id,
		input logic [15:0] burst, input logic [31:0] dl);
		in_item_t it;
		it.opcode = op;
		it.task_id = id;
		it.burst_length = burst;
		it.deadline_tick = dl;
		return it;
	endfunction

	// Tick beats with a 55 percent chance; otherwise mostly feasible tasks near the current tick, with some wild values.
	function automatic in_item_t random_beat();
		logic [15:0] b;
		logic [31:0] dl;
		if ($urandom_range(99) < 55)
			return make_beat(OP_TICK, 16'($urandom), 16'($urandom), $urandom);
		b = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		dl = tick_q + b + $urandom_range(0, 40) - 4;
		if ($urandom_range(9) == 0) dl = $urandom;
		return make_beat(OP_ARRIVE, ($urandom_range(3) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 7)), b, dl);
	endfunction

	task automatic wait_drain();
		while (pending_beats.size() > 0 || in_valid || expected_beats.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		hard_q = v;
	endtask

	initial begin
		hard_q = 1'b0; tick_q = '0; done_q = '0; fail_q = '0; tat_q = '0; halt_q = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			slot_used[i] = 1'b0;
			slot_q[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 28; recv_idle = 49;

		// Directed: idle tick, extremes, ties, zero burst, misses and a batch of late arrivals.
		write_mode(1'b0);
		pending_beats.push_back(make_beat(OP_TICK, 16'hFFFF, 16'hFFFF, MAX32));
		pending_beats.push_back(make_beat(OP_ARRIVE, 16'hFFFF, 16'd0, MAX32));
		pending_beats.push_back(make_beat(OP_ARRIVE, 16'd0, 16'hFFFF, MAX32));
		pending_beats.push_back(make_beat(OP_ARRIVE, 16'd5, 16'd1, 32'd0));
		pending_beats.push_back(make_beat(OP_ARRIVE, 16'd3, 16'd2, 32'd20));
		pending_beats.push_back(make_beat(OP_ARRIVE, 16'd2, 16'd2, 32'd20));
		for (int i = 0; i < 5; i++)
			pending_beats.push_back(make_beat(OP_TICK, 16'd0, 16'd0, 32'd0));
		for (int i = 0; i < 13; i++)
			pending_beats.push_back(make_beat(OP_ARRIVE, 16'(100 + i), 16'd1, 32'd1));
		pending_beats.push_back(make_beat(OP_TICK, 16'd0, 16'd0, 32'd0));
		wait_drain();

		// Random, soft mode.
		for (int i = 0; i < 60; i++) begin
			pending_beats.push_back(random_beat());
			wait (pending_beats.size() == 0 && !in_valid);
		end
		wait_drain();

		// Hard mode: a forced miss halts the block; later beats see halted.
		send_idle = 49; recv_idle = 28;
		write_mode(1'b1);
		for (int i = 0; i < 40; i++) begin
			pending_beats.push_back(random_beat());
			wait (pending_beats.size() == 0 && !in_valid);
		end
		pending_beats.push_back(make_beat(OP_ARRIVE, 16'd9, 16'd50, 32'd0));
		pending_beats.push_back(make_beat(OP_TICK, 16'd0, 16'd0, 32'd0));
		pending_beats.push_back(make_beat(OP_ARRIVE, 16'd1, 16'd1, MAX32));
		pending_beats.push_back(make_beat(OP_TICK, 16'd0, 16'd0, 32'd0));
		wait_drain();

		// No idling; the block stays halted, mode flipped back for coverage.
		send_idle = 0; recv_idle = 0;
		write_mode(1'b0);
		for (int i = 0; i < 30; i++) pending_beats.push_back(random_beat());
		wait_drain();

		$display("tb: %0d input beats, %0d result beats, %0d completions, %0d drops",
			sent, got, n_done, n_drop);
		$display("tb: soft and hard modes, full store, halt and idle ticks exercised");
		if (errors == 0 && expected_beats.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#20ms;
		$display("tb: done, errors");
		$finish;
	end
endmodule
